/* rtl/zdef_pkg.sv */
// Shared types, constants and helpers for the zip directory entry finder.
`default_nettype none

package zdef_pkg;

    // Longest wanted name that can ever match; capped by the 16-byte target registers.
    localparam int MAX_NAME_BYTES = 16;
    localparam int NAME_LIMIT = (MAX_NAME_BYTES < 16) ? MAX_NAME_BYTES : 16;

    localparam int POS_W = 18;
    localparam logic [POS_W-1:0] HEADER_BYTES = 18'd46;
    localparam logic [POS_W-1:0] HEADER_LAST  = 18'd45;
    localparam logic [31:0]      DIR_SIGNATURE = 32'h0201_4B50;
    localparam logic [15:0]      METHOD_STORED = 16'd0;
    localparam logic [15:0]      METHOD_DEFLATED = 16'd8;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HIGH = 2'd3;

    localparam int RESULT_DATA_W = 152;

    typedef enum logic [2:0] {
        ST_NO_MATCH  = 3'd0,
        ST_MATCH     = 3'd1,
        ST_BAD_SIG   = 3'd2,
        ST_OVERRUN   = 3'd3,
        ST_EXHAUSTED = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_directory;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t data;
    } item_req_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] compressed_size;
        logic [31:0] uncompressed_size;
        logic [31:0] local_header_offset;
        logic [15:0] method;
        logic        encrypted;
        logic        name_safe;
        logic [15:0] name_length;
        logic [15:0] record_index;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } result_req_t;

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

`default_nettype wire

/* rtl/zip_directory_entry_finder_unit.sv */
// Top level of the zip central directory entry finder.
//
// Usage: after reset, write directory_size, target_length and the two target name
// words over the cfg channel (index 0..3), with the stream idle. Then stream the
// central directory on s_*, one byte per request; set s_tuser on the first byte.
// Each finished 46-byte header plus name, extra and comment yields one m_* request;
// a match, bad signature, overrun or exhausted directory yields a final request and
// the walk then ignores bytes until the next start byte.
// A byte accepted on s_* passes from the input register through one step of the
// parser into the result register.
// Throughput: one byte per cycle, set by the single-step parser update, unless m_* stalls.
// Reset clears the walk (stopped), all configuration and empties both holding registers.
// When the receiver stalls, the held result waits; one more byte may enter the
// input register, and s_tready drops until the result is taken.
`default_nettype none

module zip_directory_entry_finder_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,  // [7:0] data_byte
    input  wire logic                                s_tuser,  // [0] start_of_directory
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [31:0] compressed_size, [63:32] uncompressed_size, [95:64] local_header_offset,
    // [111:96] method, [112] encrypted, [113] name_safe, [129:114] name_length,
    // [145:130] record_index, [151:146] zero
    output logic [zdef_pkg::RESULT_DATA_W-1:0]       m_tdata,
    output logic [2:0]                               m_tuser,  // [2:0] status
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [zdef_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [63:0]                         cfg_data
);
    import zdef_pkg::*;

    item_t       s_item;
    item_req_t   item;
    result_req_t res;
    result_t     m_result;
    logic        space;
    logic        fire;

    assign s_item.data_byte          = s_tdata;
    assign s_item.start_of_directory = s_tuser;
    assign fire      = item.valid && space;
    assign cfg_ready = aresetn;

    zdef_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .advance (fire),
        .item    (item)
    );

    zdef_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (item.data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res)
    );

    zdef_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .res      (res),
        .space    (space),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (m_result)
    );

    assign m_tuser = m_result.status;
    assign m_tdata = {6'd0,
                      m_result.record_index,
                      m_result.name_length,
                      m_result.name_safe,
                      m_result.encrypted,
                      m_result.method,
                      m_result.local_header_offset,
                      m_result.uncompressed_size,
                      m_result.compressed_size};

`ifndef ASSERT_OFF
    a_match_is_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_result.status == ST_MATCH |-> m_result.name_safe
            && !m_result.encrypted)
        else $error("match reported on unsafe or encrypted entry");

    a_overrun_unsafe: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_result.status == ST_OVERRUN |-> !m_result.name_safe)
        else $error("overrun result marked safe");

    a_stop_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_result.status == ST_BAD_SIG || m_result.status == ST_EXHAUSTED)
            |-> m_tdata[129:0] == '0)
        else $error("fields not cleared on bad signature or exhausted result");
`endif

endmodule

`default_nettype wire

/* rtl/zdef_in_reg.sv */
// Input register stage: holds one accepted byte request until the parser takes it.
`default_nettype none

module zdef_in_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire zdef_pkg::item_t   s_item,
    input  wire logic              advance,
    output zdef_pkg::item_req_t    item
);
    import zdef_pkg::*;

    logic  valid_reg, valid_next;
    item_t data_reg, data_next;

    // no request is taken while reset is held
    assign s_ready = aresetn && (!valid_reg || advance);

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
            data_next  = s_item;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

`default_nettype wire

/* rtl/zdef_parser.sv */
// Record walker: configuration registers, running parse state and one-byte step logic.
`default_nettype none

module zdef_parser (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              fire,
    input  wire zdef_pkg::item_t                   item,
    input  wire logic                              cfg_write,
    input  wire logic [zdef_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [63:0]                       cfg_data,
    output zdef_pkg::result_req_t                  res
);
    import zdef_pkg::*;

    // configuration
    logic [31:0]  dir_size_reg;
    logic [4:0]   target_len_reg;
    logic [63:0]  target_lo_reg;
    logic [63:0]  target_hi_reg;

    // walk state
    logic             stopped_reg, stopped_next;
    logic [31:0]      walked_reg, walked_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] rec_len_reg, rec_len_next;
    logic [15:0]      entry_cnt_reg, entry_cnt_next;
    logic             unsafe_reg, unsafe_next;
    logic             mismatch_reg, mismatch_next;
    logic [15:0]      prev2_reg, prev2_next;
    logic             dotdot_reg, dotdot_next;

    // header fields (payload)
    logic [31:0] csize_reg, csize_next;
    logic [31:0] usize_reg, usize_next;
    logic [31:0] lfh_reg, lfh_next;
    logic [15:0] method_reg, method_next;
    logic        encrypted_reg, encrypted_next;
    logic [15:0] name_len_reg, name_len_next;
    logic [15:0] extra_len_reg, extra_len_next;
    logic [15:0] comment_len_reg, comment_len_next;

    logic [127:0] target_name;
    assign target_name = {target_hi_reg, target_lo_reg};

    always_comb begin
        logic             cur_stopped;
        logic [31:0]      cur_walked;
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] i;
        logic [7:0]       b;
        logic [7:0]       prev;
        logic [7:0]       prevprev;
        logic [7:0]       tbyte;
        logic [1:0]       lfh_idx;
        logic             exhausted;
        logic             bad_sig;
        logic             overrun;
        logic             rec_end;
        logic             safe;
        logic             match;
        logic [32:0]      reach;

        stopped_next     = stopped_reg;
        walked_next      = walked_reg;
        pos_next         = pos_reg;
        rec_len_next     = rec_len_reg;
        entry_cnt_next   = entry_cnt_reg;
        unsafe_next      = unsafe_reg;
        mismatch_next    = mismatch_reg;
        prev2_next       = prev2_reg;
        dotdot_next      = dotdot_reg;
        csize_next       = csize_reg;
        usize_next       = usize_reg;
        lfh_next         = lfh_reg;
        method_next      = method_reg;
        encrypted_next   = encrypted_reg;
        name_len_next    = name_len_reg;
        extra_len_next   = extra_len_reg;
        comment_len_next = comment_len_reg;
        res              = '0;

        b           = item.data_byte;
        cur_stopped = item.start_of_directory ? 1'b0 : stopped_reg;
        cur_walked  = item.start_of_directory ? 32'd0 : walked_reg;
        p           = item.start_of_directory ? '0 : pos_reg;
        i           = p - HEADER_BYTES;
        prev        = 8'd0;
        prevprev    = 8'd0;
        tbyte       = 8'd0;
        lfh_idx     = 2'(p[1:0] - 2'd2);
        exhausted   = 1'b0;
        bad_sig     = 1'b0;
        overrun     = 1'b0;
        rec_end     = 1'b0;
        safe        = 1'b0;
        match       = 1'b0;
        reach       = '0;

        if (fire) begin
            if (item.start_of_directory) begin
                stopped_next   = 1'b0;
                walked_next    = 32'd0;
                pos_next       = '0;
                entry_cnt_next = 16'd0;
            end
            res.data.record_index = item.start_of_directory ? 16'd0 : entry_cnt_reg;

            if (!cur_stopped) begin
                if (p == '0) begin
                    unsafe_next   = 1'b0;
                    mismatch_next = 1'b0;
                    prev2_next    = 16'd0;
                    dotdot_next   = 1'b0;
                    rec_len_next  = HEADER_BYTES;
                    reach = {1'b0, cur_walked} + 33'(HEADER_BYTES);
                    exhausted = reach > {1'b0, dir_size_reg};
                end
                bad_sig = (p < 18'd4) && (b != DIR_SIGNATURE[8*p[1:0] +: 8]);

                if (exhausted) begin
                    res.valid       = 1'b1;
                    res.data.status = ST_EXHAUSTED;
                    stopped_next    = 1'b1;
                end else if (bad_sig) begin
                    res.valid       = 1'b1;
                    res.data.status = ST_BAD_SIG;
                    stopped_next    = 1'b1;
                end else begin
                    case (p) inside
                        18'd8:                      encrypted_next = b[0];
                        18'd10, 18'd11:             method_next[8*p[0] +: 8] = b;
                        [18'd20:18'd23]:            csize_next[8*p[1:0] +: 8] = b;
                        [18'd24:18'd27]:            usize_next[8*p[1:0] +: 8] = b;
                        18'd28, 18'd29:             name_len_next[8*p[0] +: 8] = b;
                        18'd30, 18'd31:             extra_len_next[8*p[0] +: 8] = b;
                        18'd32, 18'd33:             comment_len_next[8*p[0] +: 8] = b;
                        [18'd42:18'd45]:            lfh_next[8*lfh_idx +: 8] = b;
                        default:                    ;
                    endcase

                    if (p == HEADER_LAST) begin
                        rec_len_next = HEADER_BYTES + POS_W'(name_len_reg)
                                     + POS_W'(extra_len_reg) + POS_W'(comment_len_reg);
                        reach   = {1'b0, cur_walked} + 33'(rec_len_next);
                        overrun = reach > {1'b0, dir_size_reg};
                        rec_end = (name_len_reg == 16'd0) && (extra_len_reg == 16'd0)
                               && (comment_len_reg == 16'd0);
                    end else begin
                        rec_end = (p > HEADER_LAST) && (p + 18'd1 == rec_len_reg);
                    end

                    if (overrun) begin
                        res.valid       = 1'b1;
                        res.data.status = ST_OVERRUN;
                        stopped_next    = 1'b1;
                    end else begin
                        // entry name bytes: traversal checks and target compare
                        if (p >= HEADER_BYTES && i < POS_W'(name_len_reg)) begin
                            prev     = prev2_reg[7:0];
                            prevprev = prev2_reg[15:8];
                            if (i == '0 && (b == 8'h2F || b == 8'h5C)) unsafe_next = 1'b1;
                            if (i == 18'd1 && is_letter(prev) && b == 8'h3A) unsafe_next = 1'b1;
                            if (b == 8'h00 || b == 8'h5C) unsafe_next = 1'b1;
                            if (dotdot_reg && b == 8'h2F) unsafe_next = 1'b1;
                            dotdot_next = 1'b0;
                            if (b == 8'h2E && i >= 18'd1 && prev == 8'h2E
                                    && (i == 18'd1 || prevprev == 8'h2F)) begin
                                if (i + 18'd1 == POS_W'(name_len_reg)) begin
                                    unsafe_next = 1'b1;
                                end else begin
                                    dotdot_next = 1'b1;
                                end
                            end
                            tbyte = target_name[8*i[3:0] +: 8];
                            if (i < POS_W'(target_len_reg) && i < POS_W'(NAME_LIMIT)
                                    && tbyte != b) begin
                                mismatch_next = 1'b1;
                            end
                            prev2_next = {prev, b};
                        end

                        if (rec_end) begin
                            if (name_len_next == 16'd0) unsafe_next = 1'b1;
                            safe  = !unsafe_next;
                            match = !encrypted_next
                                 && (method_next == METHOD_STORED
                                     || method_next == METHOD_DEFLATED)
                                 && safe
                                 && name_len_next == 16'(target_len_reg)
                                 && target_len_reg <= 5'(NAME_LIMIT)
                                 && !mismatch_next;
                            res.valid       = 1'b1;
                            res.data.status = match ? ST_MATCH : ST_NO_MATCH;
                            if (match) begin
                                stopped_next = 1'b1;
                            end else begin
                                walked_next = cur_walked + 32'(rec_len_next);
                                pos_next    = '0;
                                if (res.data.record_index != 16'hFFFF) begin
                                    entry_cnt_next = res.data.record_index + 16'd1;
                                end
                            end
                        end else begin
                            pos_next = p + 18'd1;
                        end
                    end

                    if (res.valid) begin
                        res.data.compressed_size     = csize_next;
                        res.data.uncompressed_size   = usize_next;
                        res.data.local_header_offset = lfh_next;
                        res.data.method              = method_next;
                        res.data.encrypted           = encrypted_next;
                        res.data.name_safe           = safe;
                        res.data.name_length         = name_len_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_size_reg   <= 32'd0;
            target_len_reg <= 5'd0;
            target_lo_reg  <= 64'd0;
            target_hi_reg  <= 64'd0;
            stopped_reg    <= 1'b1;
            walked_reg     <= 32'd0;
            pos_reg        <= '0;
            rec_len_reg    <= HEADER_BYTES;
            entry_cnt_reg  <= 16'd0;
            unsafe_reg     <= 1'b0;
            mismatch_reg   <= 1'b0;
            prev2_reg      <= 16'd0;
            dotdot_reg     <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (cfg_index)
                    CFG_DIR_SIZE:    dir_size_reg   <= cfg_data[31:0];
                    CFG_TARGET_LEN:  target_len_reg <= cfg_data[4:0];
                    CFG_TARGET_LOW:  target_lo_reg  <= cfg_data;
                    CFG_TARGET_HIGH: target_hi_reg  <= cfg_data;
                    default:         ;
                endcase
            end
            stopped_reg   <= stopped_next;
            walked_reg    <= walked_next;
            pos_reg       <= pos_next;
            rec_len_reg   <= rec_len_next;
            entry_cnt_reg <= entry_cnt_next;
            unsafe_reg    <= unsafe_next;
            mismatch_reg  <= mismatch_next;
            prev2_reg     <= prev2_next;
            dotdot_reg    <= dotdot_next;
        end
        csize_reg       <= csize_next;
        usize_reg       <= usize_next;
        lfh_reg         <= lfh_next;
        method_reg      <= method_next;
        encrypted_reg   <= encrypted_next;
        name_len_reg    <= name_len_next;
        extra_len_reg   <= extra_len_next;
        comment_len_reg <= comment_len_next;
    end

`ifndef ASSERT_OFF
    a_stop_after_final: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.valid && res.data.status != ST_NO_MATCH |=> stopped_reg)
        else $error("walk kept going after a terminating result");

    a_result_needs_fire: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> fire)
        else $error("result produced without a byte");

    a_pos_in_record: assert property (@(posedge aclk) disable iff (!aresetn)
        !stopped_reg && pos_reg > HEADER_LAST |-> pos_reg < rec_len_reg)
        else $error("record position ran past record length");
`endif

endmodule

`default_nettype wire

/* rtl/zdef_out_reg.sv */
// Result register: holds one result request until the receiver takes it.
`default_nettype none

module zdef_out_reg (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   load,
    input  wire zdef_pkg::result_req_t  res,
    output logic                        space,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output zdef_pkg::result_t           m_result
);
    import zdef_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg, data_next;

    // a slot frees up in the same cycle the receiver takes the held result
    assign space = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load && res.valid) begin
            valid_next = 1'b1;
            data_next  = res.data;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_valid  = valid_reg;
    assign m_result = data_reg;

endmodule

`default_nettype wire
